>>> src/aesd_pkg.sv
package aesd_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_INIT,
        ST_ROUND,
        ST_DONE
    } state_t;

    typedef enum logic [0:0] {
        REG_KEY_UPPER = 1'b0,
        REG_KEY_LOWER = 1'b1
    } reg_index_t;

    localparam int unsigned CFG_INDEX_WIDTH = 1;

    // Multiply by x in GF(2^8)
    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Forward S-box
    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [0:255];
        t = '{
            8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
            8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
            8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
            8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
            8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
            8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
            8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
            8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
            8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
            8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
            8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
            8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
            8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
            8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
            8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
            8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
        };
        sbox = t[a];
    endfunction

    // Inverse S-box
    function automatic logic [7:0] inv_sbox(input logic [7:0] a);
        logic [7:0] t [0:255];
        t = '{
            8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
            8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
            8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
            8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
            8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
            8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
            8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
            8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
            8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
            8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
            8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
            8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
            8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
            8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
            8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
            8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
        };
        inv_sbox = t[a];
    endfunction

    // Inverse MixColumns on one column, byte 0 in the top bits
    function automatic logic [31:0] inv_mix_col(input logic [31:0] col);
        logic [7:0] a [0:3];
        logic [7:0] x2 [0:3];
        logic [7:0] x4 [0:3];
        logic [7:0] x8 [0:3];
        logic [7:0] m9 [0:3];
        logic [7:0] mb [0:3];
        logic [7:0] md [0:3];
        logic [7:0] me [0:3];
        for (int i = 0; i < 4; i++)
        begin
            a[i]  = col[31-8*i -: 8];
            x2[i] = xtime(a[i]);
            x4[i] = xtime(x2[i]);
            x8[i] = xtime(x4[i]);
            m9[i] = x8[i] ^ a[i];
            mb[i] = x8[i] ^ x2[i] ^ a[i];
            md[i] = x8[i] ^ x4[i] ^ a[i];
            me[i] = x8[i] ^ x4[i] ^ x2[i];
        end
        inv_mix_col = {me[0] ^ mb[1] ^ md[2] ^ m9[3],
                       m9[0] ^ me[1] ^ mb[2] ^ md[3],
                       md[0] ^ m9[1] ^ me[2] ^ mb[3],
                       mb[0] ^ md[1] ^ m9[2] ^ me[3]};
    endfunction

endpackage

>>> src/aesd_stream_if.sv
interface aesd_stream_if;
    logic        valid;
    logic        ready;
    logic [63:0] upper;
    logic [63:0] lower;

    modport source (output valid, output upper, output lower, input ready);
    modport sink (input valid, input upper, input lower, output ready);
endinterface

>>> src/aesd_cfg_if.sv
interface aesd_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [aesd_pkg::CFG_INDEX_WIDTH-1:0] index;
    logic [63:0]                         data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> src/aes128_block_decrypt.sv
// AES-128 block decryption, one shared round unit.
// Channels: cfg writes the key (index 0 = upper 64 bits, 1 = lower 64 bits);
// in_ch takes a ciphertext block (upper = bytes 0..7), out_ch returns the
// plaintext block. All use valid/ready; a transfer happens when both are high.
// Key expansion runs after a key write, on the next block, one round-key word
// per cycle from the key schedule's S-box column unit. Per block: initial key
// addition, ten rounds through the round unit (one round per cycle), then the
// output register is loaded. The block takes a new input only when idle with
// the output register empty, so it takes no new block before the last one has
// been taken from the output.
// A pending key write is taken ahead of a block offered in the same cycle.
// The result sits in an output register until the receiver takes it; while
// out_ch is stalled the block takes no new input.
// Reset returns control to idle, clears the key registers to zero and marks the
// expansion stale; the round-key store holds nothing valid until expanded.
module aes128_block_decrypt #(
    parameter int ROUNDS = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    aesd_cfg_if.sink           cfg,
    aesd_stream_if.sink        in_ch,
    aesd_stream_if.source      out_ch
);
    localparam int TOTAL_WORDS = 4 * (ROUNDS + 1);
    localparam int WIDX_W      = $clog2(TOTAL_WORDS + 1);
    localparam int RIDX_W      = $clog2(ROUNDS + 1);

    aesd_pkg::state_t state_reg, state_next;

    logic [63:0]        key_upper_reg;
    logic [63:0]        key_lower_reg;
    logic               expanded_reg;
    logic [WIDX_W-1:0]  widx_reg;
    logic [7:0]         rcon_reg;
    logic [RIDX_W-1:0]  round_reg;
    logic [127:0]       blk_reg;
    logic [127:0]       blk_next;
    logic [127:0]       out_reg;
    logic               out_valid_reg;
    logic [31:0]        w_prev_reg;
    logic [31:0]        w_back [0:3];

    logic [127:0]       rk_store [0:ROUNDS];
    logic [127:0]       rk_q;

    logic               cfg_fire;
    logic               in_fire;
    logic               out_fire;
    logic [31:0]        new_word;
    logic [31:0]        temp_word;
    logic [RIDX_W-1:0]  rk_rd_idx;
    logic               rk_wr_en;
    logic [RIDX_W-1:0]  rk_wr_row;
    logic [127:0]       rk_wr_data;
    logic [127:0]       shift_sub;
    logic [127:0]       keyed;
    logic [127:0]       mixed;

    assign cfg.ready   = (state_reg == aesd_pkg::ST_IDLE);
    assign cfg_fire    = cfg.valid && cfg.ready;
    assign in_ch.ready = (state_reg == aesd_pkg::ST_IDLE) && !out_valid_reg && !cfg.valid;
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.upper = out_reg[127:64];
    assign out_ch.lower = out_reg[63:0];
    assign out_fire    = out_ch.valid && out_ch.ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            aesd_pkg::ST_IDLE:
                if (in_fire)
                    state_next = expanded_reg ? aesd_pkg::ST_INIT : aesd_pkg::ST_EXPAND;
            aesd_pkg::ST_EXPAND:
                if (widx_reg == WIDX_W'(TOTAL_WORDS - 1))
                    state_next = aesd_pkg::ST_INIT;
            aesd_pkg::ST_INIT:
                state_next = aesd_pkg::ST_ROUND;
            aesd_pkg::ST_ROUND:
                if (round_reg == RIDX_W'(0))
                    state_next = aesd_pkg::ST_DONE;
            aesd_pkg::ST_DONE:
                state_next = aesd_pkg::ST_IDLE;
            default:
                state_next = aesd_pkg::ST_IDLE;
        endcase
    end

    // Key schedule word: the S-box column on every fourth word
    always_comb
    begin
        temp_word = w_prev_reg;
        if (widx_reg[1:0] == 2'b00)
        begin
            temp_word = {aesd_pkg::sbox(w_prev_reg[23:16]) ^ rcon_reg,
                         aesd_pkg::sbox(w_prev_reg[15:8]),
                         aesd_pkg::sbox(w_prev_reg[7:0]),
                         aesd_pkg::sbox(w_prev_reg[31:24])};
        end
        new_word = w_back[0] ^ temp_word;
    end

    // Round unit: InvShiftRows, InvSubBytes, AddRoundKey, InvMixColumns
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                shift_sub[127 - 8*(4*c + r) -: 8] =
                    aesd_pkg::inv_sbox(blk_reg[127 - 8*(4*((c + 4 - r) % 4) + r) -: 8]);
            end
        end
        keyed = shift_sub ^ rk_q;
        for (int c = 0; c < 4; c++)
            mixed[127 - 32*c -: 32] = aesd_pkg::inv_mix_col(keyed[127 - 32*c -: 32]);
    end

    // Block register next value
    always_comb
    begin
        blk_next = blk_reg;
        unique case (state_reg)
            aesd_pkg::ST_INIT:
                blk_next = blk_reg ^ rk_q;
            aesd_pkg::ST_ROUND:
                blk_next = (round_reg == RIDX_W'(0)) ? keyed : mixed;
            default:
                blk_next = blk_reg;
        endcase
    end

    // Round-key read address: one ahead of the round in use
    always_comb
    begin
        unique case (state_reg)
            aesd_pkg::ST_INIT:
                rk_rd_idx = RIDX_W'(ROUNDS - 1);
            aesd_pkg::ST_ROUND:
                rk_rd_idx = (round_reg == RIDX_W'(0)) ? RIDX_W'(0) : round_reg - RIDX_W'(1);
            default:
                rk_rd_idx = RIDX_W'(ROUNDS);
        endcase
    end

    // Round-key write port: key words on the starting transfer, then one row per four words
    always_comb
    begin
        rk_wr_en   = 1'b0;
        rk_wr_row  = RIDX_W'(0);
        rk_wr_data = {key_upper_reg, key_lower_reg};
        if (in_fire && !expanded_reg)
            rk_wr_en = 1'b1;
        else if (state_reg == aesd_pkg::ST_EXPAND && widx_reg[1:0] == 2'b11)
        begin
            rk_wr_en   = 1'b1;
            rk_wr_row  = widx_reg[WIDX_W-1:2];
            rk_wr_data = {w_back[1], w_back[2], w_back[3], new_word};
        end
    end

    // Round-key store, one 128-bit row per round; registered read, new row forwarded
    always_ff @(posedge clk)
    begin
        if (rk_wr_en)
            rk_store[rk_wr_row] <= rk_wr_data;
        if (rk_wr_en && rk_wr_row == rk_rd_idx)
            rk_q <= rk_wr_data;
        else
            rk_q <= rk_store[rk_rd_idx];
    end

    // Control and payload registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= aesd_pkg::ST_IDLE;
            key_upper_reg <= '0;
            key_lower_reg <= '0;
            expanded_reg  <= 1'b0;
            widx_reg      <= '0;
            rcon_reg      <= 8'h01;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Hold key; drop expansion on any write
            if (cfg_fire)
            begin
                unique case (cfg.index)
                    aesd_pkg::REG_KEY_UPPER: key_upper_reg <= cfg.data;
                    aesd_pkg::REG_KEY_LOWER: key_lower_reg <= cfg.data;
                    default: ;
                endcase
                expanded_reg <= 1'b0;
            end

            // Start expansion with the four key words
            if (in_fire && !expanded_reg)
            begin
                widx_reg <= WIDX_W'(4);
                rcon_reg <= 8'h01;
            end
            else if (state_reg == aesd_pkg::ST_EXPAND)
            begin
                widx_reg <= widx_reg + WIDX_W'(1);
                if (widx_reg[1:0] == 2'b00)
                    rcon_reg <= aesd_pkg::xtime(rcon_reg);
                if (widx_reg == WIDX_W'(TOTAL_WORDS - 1))
                    expanded_reg <= 1'b1;
            end

            if (state_reg == aesd_pkg::ST_INIT)
                round_reg <= RIDX_W'(ROUNDS - 1);
            else if (state_reg == aesd_pkg::ST_ROUND && round_reg != RIDX_W'(0))
                round_reg <= round_reg - RIDX_W'(1);

            // Present result; drop on transfer
            if (state_reg == aesd_pkg::ST_DONE)
                out_valid_reg <= 1'b1;
            else if (out_fire)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            blk_reg <= {in_ch.upper, in_ch.lower};
            w_back[0] <= key_upper_reg[63:32];
            w_back[1] <= key_upper_reg[31:0];
            w_back[2] <= key_lower_reg[63:32];
            w_back[3] <= key_lower_reg[31:0];
            w_prev_reg <= key_lower_reg[31:0];
        end
        else
        begin
            blk_reg <= blk_next;
            if (state_reg == aesd_pkg::ST_EXPAND)
            begin
                w_back[0] <= w_back[1];
                w_back[1] <= w_back[2];
                w_back[2] <= w_back[3];
                w_back[3] <= new_word;
                w_prev_reg <= new_word;
            end
        end
        if (state_reg == aesd_pkg::ST_DONE)
            out_reg <= blk_reg;
    end

endmodule
